FILE: hw/rtl/m3sp_pkg.sv
// m3sp_pkg: shared types and widths of the median-of-three secded packetizer
// no dependencies
`timescale 1ns / 1ps

package m3sp_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned RadioW   = 26;
  localparam int unsigned DataW    = 16;
  // bit of the readout word that marks a valid sample
  localparam int unsigned ValidBit = 1;

  // one complete group of three samples, in arrival order
  typedef struct packed {
    logic [SampleW-1:0] first;
    logic [SampleW-1:0] second;
    logic [SampleW-1:0] third;
  } m3sp_group_t;

endpackage

FILE: hw/rtl/m3sp_if.sv
// m3sp_in_if / m3sp_out_if: valid/ready channels of the packetizer
// depends on m3sp_pkg
`timescale 1ns / 1ps

interface m3sp_in_if
  import m3sp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] readout_word;

  modport source (output valid, output readout_word, input ready);
  modport sink   (input valid, input readout_word, output ready);
endinterface

interface m3sp_out_if
  import m3sp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RadioW-1:0]  radio_word;
  logic [SampleW-1:0] median_sample;

  modport source (output valid, output radio_word, output median_sample, input ready);
  modport sink   (input valid, input radio_word, input median_sample, output ready);
endinterface

FILE: hw/rtl/m3sp_front.sv
// m3sp_front: filters invalid readouts and gathers groups of three samples
// depends on m3sp_pkg and m3sp_in_if
`timescale 1ns / 1ps

module m3sp_front
  import m3sp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  m3sp_in_if.sink      in_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output m3sp_group_t  push_group_o
);

  logic [1:0]         count_q, count_d;
  logic [SampleW-1:0] store_q [2];
  logic               sample_ok;
  logic               group_full;
  logic               accept;

  assign sample_ok  = in_i.readout_word[ValidBit];
  // a count of three cannot occur, it behaves like two
  assign group_full = count_q[1];
  assign in_i.ready = !group_full || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign push_valid_o        = accept && sample_ok && group_full;
  assign push_group_o.first  = store_q[0];
  assign push_group_o.second = store_q[1];
  assign push_group_o.third  = in_i.readout_word;

  always_comb begin
    count_d = count_q;
    if (accept && sample_ok) begin
      if (group_full) begin
        count_d = 2'd0;
      end else begin
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && sample_ok && !group_full) begin
      store_q[count_q[0]] <= in_i.readout_word;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("sample count reached three");
  a_group_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |=> count_q == 2'd0)
    else $error("count did not clear after a full group");
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> push_ready_i)
    else $error("group pushed into a full queue");
`endif

endmodule

FILE: hw/rtl/m3sp_fifo.sv
// m3sp_fifo: short queue of sample groups between front and back
// depends on m3sp_pkg
`timescale 1ns / 1ps

module m3sp_fifo
  import m3sp_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  m3sp_group_t push_group_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output m3sp_group_t pop_group_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  m3sp_group_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != FullCnt;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_group_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");
  a_ptrs_meet_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue empty but pointers differ");
`endif

endmodule

FILE: hw/rtl/m3sp_back.sv
// m3sp_back: picks the median of a group and builds the secded radio word
// depends on m3sp_pkg and m3sp_out_if
`timescale 1ns / 1ps

module m3sp_back
  import m3sp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  m3sp_group_t pop_group_i,
  m3sp_out_if.source  out_o
);

  localparam logic [3:0]       Preamble = 4'b1111;
  localparam logic [DataW-1:0] P5Mask   = 16'hF800;
  localparam logic [DataW-1:0] P4Mask   = 16'h07F0;
  localparam logic [DataW-1:0] P3Mask   = 16'hC78E;
  localparam logic [DataW-1:0] P2Mask   = 16'h366D;
  localparam logic [DataW-1:0] P1Mask   = 16'hAD5B;

  logic               out_valid_q;
  logic [RadioW-1:0]  radio_q, radio_d;
  logic [SampleW-1:0] median_q, median_d;
  logic [SampleW-1:0] lo, hi, mid;
  logic [DataW-1:0]   data;
  logic [4:0]         par;
  logic               pop;

  always_comb begin
    lo  = (pop_group_i.first < pop_group_i.second) ? pop_group_i.first : pop_group_i.second;
    hi  = (pop_group_i.first < pop_group_i.second) ? pop_group_i.second : pop_group_i.first;
    mid = (hi < pop_group_i.third) ? hi : pop_group_i.third;
    median_d = (lo > mid) ? lo : mid;
  end

  always_comb begin
    data    = median_d[DataW-1:0];
    par[4]  = ^(data & P5Mask);
    par[3]  = ^(data & P4Mask);
    par[2]  = ^(data & P3Mask);
    par[1]  = ^(data & P2Mask);
    par[0]  = ^(data & P1Mask);
    // last bit is overall parity over data and the five check bits
    radio_d = {Preamble, data, par, (^data) ^ (^par)};
  end

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      radio_q  <= radio_d;
      median_q <= median_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.radio_word    = radio_q;
  assign out_o.median_sample = median_q;

`ifndef ASSERT_OFF
  a_new_result_popped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop))
    else $error("result appeared without a queue transaction");
`endif

endmodule

FILE: hw/rtl/median_of_three_secded_packetizer_top.sv
// Sustains one readout transaction per clock while the group queue has room. Readouts
// with bit 1 clear are dropped; every third valid readout closes a group, and the median
// of the group (unsigned) leaves as a 26-bit secded radio word plus the full median word,
// registered first in the group queue and then in the output register. The queue holds
// QDepth groups, so the input keeps flowing while a result waits.
// depends on m3sp_pkg, m3sp_if, m3sp_front, m3sp_fifo, m3sp_back
`timescale 1ns / 1ps

module median_of_three_secded_packetizer_top
  import m3sp_pkg::*;
#(
  parameter int unsigned QDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  m3sp_in_if.sink     in_i,
  m3sp_out_if.source  out_o
);

  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  m3sp_group_t push_group, pop_group;

  m3sp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_group_o (push_group)
  );

  m3sp_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_group_i (push_group),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_group_o  (pop_group)
  );

  m3sp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_group_i (pop_group),
    .out_o       (out_o)
  );

endmodule
